FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion wrappers, clocked on clk; ASSERT_CLK is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg
// Types and constants of the 5x5 RGB median filter.
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int RADIUS     = 2;
  localparam int WIN        = 2 * RADIUS + 1;
  localparam int LINES      = 2 * RADIUS;
  localparam int WIN_COUNT  = WIN * WIN;
  localparam int MED_RANK   = WIN_COUNT / 2;
  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int POS_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int RANK_W     = $clog2(WIN_COUNT);
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef pixel_t [WIN_COUNT-1:0] window_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pos_t;

  // lowest bits first: red, green, blue, row, col
  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  red;
  } result_t;

  // pixel packing: red high, blue low
  function automatic logic [CH_W-1:0] chan(input pixel_t p, input int ch);
    logic [CH_W-1:0] v;
    v = p[(2 - ch) * CH_W +: CH_W];
    return v;
  endfunction

endpackage

FILE: sv/rmf_ram.sv
// ----------------------------------------------------------------------------
// rmf_ram
// Generic single-write, single-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module rmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/rmf_median.sv
// ----------------------------------------------------------------------------
// rmf_median
// Three-stage rank-select median of 25 values per color channel.
// ----------------------------------------------------------------------------
module rmf_median import rmf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  window_t in_win,
  input  pos_t    in_pos,
  output logic    out_valid,
  output result_t out_res
);

  logic [2:0][WIN_COUNT-1:0][WIN_COUNT-1:0] le;
  logic [2:0][WIN_COUNT-1:0][RANK_W-1:0]    rank, rank_next;
  logic [2:0][CH_W-1:0]                     med_next;
  window_t win1, win2;
  pos_t    pos1, pos2;
  logic    v1, v2;

  // stage 1: pairwise compares, i before j when v[i] <= v[j]
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < WIN_COUNT; i++) begin
        for (int j = 0; j < WIN_COUNT; j++) begin
          le[ch][i][j] <= (j > i) ? (chan(in_win[i], ch) <= chan(in_win[j], ch)) : 1'b0;
        end
      end
    end
    win1 <= in_win;
    pos1 <= in_pos;
  end

  // stage 2: rank of each element
  always_comb begin
    logic [WIN_COUNT-1:0] ahead;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < WIN_COUNT; i++) begin
        for (int j = 0; j < WIN_COUNT; j++) begin
          if (j < i) begin
            ahead[j] = le[ch][j][i];
          end else if (j > i) begin
            ahead[j] = ~le[ch][i][j];
          end else begin
            ahead[j] = 1'b0;
          end
        end
        rank_next[ch][i] = RANK_W'($countones(ahead));
      end
    end
  end

  always_ff @(posedge clk) begin
    rank <= rank_next;
    win2 <= win1;
    pos2 <= pos1;
  end

  // stage 3: pick the element of middle rank
  always_comb begin
    med_next = '0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < WIN_COUNT; i++) begin
        if (rank[ch][i] == RANK_W'(MED_RANK)) begin
          med_next[ch] = med_next[ch] | chan(win2[i], ch);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res.red   <= med_next[0];
    out_res.green <= med_next[1];
    out_res.blue  <= med_next[2];
    out_res.row   <= pos2.row;
    out_res.col   <= pos2.col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

FILE: sv/rgb_median_filter_5x5.sv
// ----------------------------------------------------------------------------
// rgb_median_filter_5x5
// Streaming 5x5 per-channel median filter over RGB pixels in raster order.
// ----------------------------------------------------------------------------
// channel  dir  beat
// s_*      in   pixel: red, green, blue in tdata, frame start in tuser
// m_*      out  medians and window center position
// cfg_*    in   register write: index, data
//
// One pixel per cycle while s_tready is high; results pass s1, window, median, FIFO.
// Four line buffers live in one 1024 x 96 RAM, read and written once per beat
// at the column; back-to-back beats to the same column are forwarded.
// Results queue in a 16-entry FIFO; s_tready drops only when 16 results
// are outstanding. Reset clears counters, pipeline valids and the FIFO.
// ----------------------------------------------------------------------------
module rgb_median_filter_5x5 import rmf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic              s_tuser,   // frame_start
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,   // median red, green, blue, center_row, center_col
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  logic [SIZE_W-1:0] image_width, image_height, width_use, height_use;
  logic [POS_W-1:0]  col_cnt, row_cnt, col_cur, row_cur, col_next, row_next;
  logic [SIZE_W-1:0] col_inc, row_inc;
  logic              accept, produce;

  logic              s1_valid, s1_prod;
  logic [POS_W-1:0]  s1_col, s1_row;
  pixel_t            s1_pix;
  logic [LINES*PIX_W-1:0] ram_q, col_old, wr_word, fwd_data;
  logic              fwd_hit;
  pixel_t [WIN-1:0]  col_vec;
  pixel_t [WIN-1:0][WIN-1:0] win;
  window_t           win_flat;
  logic              med_in_valid, med_out_valid;
  pos_t              med_pos;
  result_t           med_res;

  result_t              fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_AW:0]     fifo_cnt, reserved;
  logic                 push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < SIZE_W'(WIN)) begin
      width_use = SIZE_W'(WIN);
    end else if (image_width > SIZE_W'(MAX_WIDTH)) begin
      width_use = SIZE_W'(MAX_WIDTH);
    end else begin
      width_use = image_width;
    end
    if (image_height < SIZE_W'(WIN)) begin
      height_use = SIZE_W'(WIN);
    end else if (image_height > SIZE_W'(MAX_HEIGHT)) begin
      height_use = SIZE_W'(MAX_HEIGHT);
    end else begin
      height_use = image_height;
    end
  end

  assign s_tready = reserved < (FIFO_AW+1)'(FIFO_DEPTH);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    col_cur = s_tuser ? '0 : col_cnt;
    row_cur = s_tuser ? '0 : row_cnt;
    produce = (row_cur >= POS_W'(LINES)) && (col_cur >= POS_W'(LINES));
    col_inc = {1'b0, col_cur} + SIZE_W'(1);
    row_inc = {1'b0, row_cur} + SIZE_W'(1);
    if (col_inc >= width_use) begin
      col_next = '0;
      row_next = (row_inc >= height_use) ? '0 : row_inc[POS_W-1:0];
    end else begin
      col_next = col_inc[POS_W-1:0];
      row_next = ({1'b0, row_cur} >= height_use) ? '0 : row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt <= col_next;
        row_cnt <= row_next;
      end
      s1_valid <= accept;
      fwd_hit  <= accept && s1_valid && (col_cur == s1_col);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col  <= col_cur;
      s1_row  <= row_cur;
      s1_prod <= produce;
      s1_pix  <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    end
    fwd_data <= wr_word;
  end

  rmf_ram #(
    .WIDTH (LINES * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col[ADDR_W-1:0]),
    .wr_data (wr_word),
    .rd_en   (accept),
    .rd_addr (col_cur[ADDR_W-1:0]),
    .rd_data (ram_q)
  );

  always_comb begin
    col_old = fwd_hit ? fwd_data : ram_q;
    for (int k = 0; k < LINES; k++) begin
      col_vec[k] = col_old[k*PIX_W +: PIX_W];
    end
    col_vec[LINES] = s1_pix;
    wr_word = {s1_pix, col_old[LINES*PIX_W-1:PIX_W]};
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
        win[i][WIN-1] <= col_vec[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      med_in_valid <= 1'b0;
    end else begin
      med_in_valid <= s1_valid && s1_prod;
    end
  end

  always_ff @(posedge clk) begin
    med_pos.row <= s1_row - POS_W'(RADIUS);
    med_pos.col <= s1_col - POS_W'(RADIUS);
  end

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        win_flat[i*WIN + j] = win[i][j];
      end
    end
  end

  rmf_median u_median (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (med_in_valid),
    .in_win    (win_flat),
    .in_pos    (med_pos),
    .out_valid (med_out_valid),
    .out_res   (med_res)
  );

  assign push     = med_out_valid;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = fifo_cnt != '0;
  assign m_tdata  = {4'b0, fifo[rd_ptr]};

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= med_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      reserved <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_cnt <= fifo_cnt + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
      reserved <= reserved + (FIFO_AW+1)'(accept && produce) - (FIFO_AW+1)'(pop);
    end
  end

endmodule

FILE: sv/rmf_checker.sv
// ----------------------------------------------------------------------------
// rmf_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmf_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled beat changed")
  `ASSERT_CLK(a_pad_zero, m_tvalid |-> m_tdata[47:44] == 4'd0, "tdata pad bits set")
  `ASSERT_CLK(a_col_range, m_tvalid |-> m_tdata[43:34] <= 10'd1021, "center column out of range")
  `ASSERT_ALWAYS(a_rst_idle, $past(rst) |-> !m_tvalid, "output beat right after reset")

endmodule

bind rgb_median_filter_5x5 rmf_checker u_rmf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// rgb_median_filter_5x5 testbench
// Streams RGB frames of many sizes through the filter. An in-bench model
// predicts each window median and center position; results are checked in
// order, field by field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import rmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [23:0]       s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [47:0]       m_tdata;
  logic              cfg_valid;
  logic              cfg_ready;
  cfg_reg_t          cfg_index;
  logic [SIZE_W-1:0] cfg_data;

  rgb_median_filter_5x5 uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // filter model state; pixels held in tdata layout (red low)
  logic [SIZE_W-1:0] width_reg, height_reg;
  logic [23:0]       line_mem [LINES][MAX_WIDTH];
  logic [23:0]       win [WIN][WIN];
  int unsigned       col_pos, row_pos;
  result_t           pending_medians[$];

  int unsigned pixels_sent, medians_seen, frames_sent, mismatches, cycles;
  bit          calm;        // no idling on either side
  bit          sink_busy;   // long output stall phase

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rgb_median_filter_5x5 verification failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v, int unsigned hi);
    if (v < WIN) return WIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] window_median(int sh);
    logic [7:0] v[WIN_COUNT];
    logic [7:0] x;
    int n, k;
    n = 0;
    for (int i = 0; i < WIN; i++)
      for (int j = 0; j < WIN; j++) begin
        x = win[i][j][sh +: 8];
        k = n;
        while (k > 0 && v[k-1] > x) begin
          v[k] = v[k-1];
          k--;
        end
        v[k] = x;
        n++;
      end
    return v[MED_RANK];
  endfunction

  task automatic predict_pixel(logic [23:0] pix, logic fs);
    int unsigned w, h, c, r;
    logic [23:0] column[WIN];
    result_t res;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    for (int k = 0; k < LINES; k++)
      column[k] = (c < MAX_WIDTH) ? line_mem[k][c] : '0;
    column[LINES] = pix;
    if (c < MAX_WIDTH)
      for (int k = 0; k < LINES; k++) line_mem[k][c] = column[k+1];
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN - 1; j++) win[i][j] = win[i][j+1];
      win[i][WIN-1] = column[i];
    end
    if (r >= LINES && c >= LINES) begin
      res.red   = window_median(0);
      res.green = window_median(8);
      res.blue  = window_median(16);
      res.row   = POS_W'(r - RADIUS);
      res.col   = POS_W'(c - RADIUS);
      pending_medians = {pending_medians, res};
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end else if (r >= h) begin
      r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  function automatic int gap_len();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      medians_seen++;
      if (pending_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
      end else begin
        want = pending_medians.pop_front();
        if (got !== want || m_tdata[47:$bits(result_t)] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp r%0d g%0d b%0d @(%0d,%0d) got r%0d g%0d b%0d @(%0d,%0d) hi %h",
                     want.red, want.green, want.blue, want.row, want.col,
                     got.red, got.green, got.blue, got.row, got.col,
                     m_tdata[47:$bits(result_t)]);
        end
      end
    end
  end

  // output backpressure
  always @(negedge clk) begin
    int p;
    p = $urandom_range(0, 99);
    if (rst) m_tready = 1'b0;
    else if (calm) m_tready = 1'b1;
    else if (sink_busy) m_tready = (p < 10);
    else m_tready = (p < 75);
  end

  task automatic send_pixel(logic [23:0] pix, logic fs);
    int g;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = pix;
    s_tuser  = fs;
    do @(posedge clk); while (!s_tready);
    predict_pixel(pix, fs);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [SIZE_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_size(int w, int h);
    write_reg(REG_IMAGE_WIDTH, SIZE_W'(w));
    write_reg(REG_IMAGE_HEIGHT, SIZE_W'(h));
  endtask

  // pattern: 0 random, 1 zeros, 2 ones, 3 checker, 4 ramp
  task automatic send_frame(int w, int h, int pattern, bit with_start);
    logic [23:0] pix;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        case (pattern)
          1: pix = '0;
          2: pix = '1;
          3: pix = ((r + c) % 2) ? 24'haaaaaa : 24'h555555;
          4: pix = {8'(c * 37), 8'(255 - r * 29), 8'(r * 11 + c)};
          default: pix = $urandom();
        endcase
        send_pixel(pix, with_start && r == 0 && c == 0);
      end
    frames_sent++;
  endtask

  task automatic test_reset_size();
    calm = 1;
    send_frame(40, 1, 0, 1);    // first pixels of a row at the reset size
    calm = 0;
  endtask

  task automatic test_smallest();
    set_size(5, 5);
    for (int p = 1; p <= 4; p++) send_frame(5, 5, p, 1);
    send_frame(5, 5, 0, 0);     // wraps into a new frame without a start flag
    send_frame(5, 5, 0, 1);
  endtask

  task automatic test_clamping();
    set_size(3, 0);             // both below the window
    send_frame(5, 6, 0, 1);
    set_size(6, 2047);          // tall frame, partial
    send_frame(6, 9, 0, 1);
  endtask

  task automatic test_random_frames();
    int w, h, n, cut;
    bit need_start;
    n = 0;
    need_start = 1;
    while (n < 1650) begin
      if (n == 0 || $urandom_range(0, 3) == 0) begin
        w = $urandom_range(5, 14);
        h = $urandom_range(5, 9);
        set_size(w, h);
        need_start = 1;
      end else begin
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
      end
      calm = ($urandom_range(0, 4) == 0);
      sink_busy = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // aborted frame: opens with a start, stray starts inside, then cut short
        cut = $urandom_range(1, w * h);
        for (int i = 0; i < cut; i++)
          send_pixel($urandom(), (i == 0) || ($urandom_range(0, 19) == 0));
        n += cut;
        need_start = 1;
      end else begin
        send_frame(w, h, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0,
                   need_start || ($urandom_range(0, 7) != 0));
        n += w * h;
        need_start = 0;
      end
    end
    calm = 0;
    sink_busy = 0;
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    calm = 0;
    sink_busy = 0;
    width_reg = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    col_pos = 0;
    row_pos = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_size();
    test_smallest();
    test_clamping();
    test_random_frames();

    @(negedge clk);
    s_tvalid = 1'b0;
    waited = 0;
    while (pending_medians.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (pending_medians.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", pending_medians.size());
    end
    $display("sent %0d pixels in %0d frames, checked %0d window medians",
             pixels_sent, frames_sent, medians_seen);
    $display("sizes from 5x5 to 14x9, clamped sizes, unflagged and aborted frames");
    if (mismatches == 0) begin
      $display("rgb_median_filter_5x5 verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("rgb_median_filter_5x5 verification failed");
    end
    $finish;
  end

endmodule
